// File: sv/fsa_pkg.sv
// Shared types, operation codes and helper functions for the four-state ALU.
// Used by the cell, chain, top level and testbench; depends on nothing.
`default_nettype none
package fsa_pkg;

  localparam int DW = 64;

  localparam logic [4:0] CMD_EQ    = 5'd0;
  localparam logic [4:0] CMD_CASE  = 5'd1;
  localparam logic [4:0] CMD_CASEZ = 5'd2;
  localparam logic [4:0] CMD_CASEX = 5'd3;
  localparam logic [4:0] CMD_WILD  = 5'd4;
  localparam logic [4:0] CMD_NE    = 5'd5;
  localparam logic [4:0] CMD_LTU   = 5'd6;
  localparam logic [4:0] CMD_LEU   = 5'd7;
  localparam logic [4:0] CMD_GTU   = 5'd8;
  localparam logic [4:0] CMD_GEU   = 5'd9;
  localparam logic [4:0] CMD_LTS   = 5'd10;
  localparam logic [4:0] CMD_LES   = 5'd11;
  localparam logic [4:0] CMD_GTS   = 5'd12;
  localparam logic [4:0] CMD_GES   = 5'd13;
  localparam logic [4:0] CMD_AND   = 5'd14;
  localparam logic [4:0] CMD_OR    = 5'd15;
  localparam logic [4:0] CMD_XOR   = 5'd16;
  localparam logic [4:0] CMD_ADDU  = 5'd17;
  localparam logic [4:0] CMD_SUBU  = 5'd18;
  localparam logic [4:0] CMD_MULU  = 5'd19;
  localparam logic [4:0] CMD_POWU  = 5'd20;
  localparam logic [4:0] CMD_DIVU  = 5'd21;
  localparam logic [4:0] CMD_MODU  = 5'd22;
  localparam logic [4:0] CMD_ADDS  = 5'd23;
  localparam logic [4:0] CMD_SUBS  = 5'd24;
  localparam logic [4:0] CMD_MULS  = 5'd25;
  localparam logic [4:0] CMD_POWS  = 5'd26;
  localparam logic [4:0] CMD_DIVS  = 5'd27;
  localparam logic [4:0] CMD_REMS  = 5'd28;
  localparam logic [4:0] CMD_MODS  = 5'd29;

  // one request as it travels down the chain
  typedef struct packed {
    logic [4:0]    cmd;
    logic [DW-1:0] mask;
    logic          fin;    // result already settled before the chain
    logic [DW-1:0] fval;
    logic [DW-1:0] funk;
    logic          ln;
    logic          rn;
    logic [DW-1:0] rv;
    logic [DW-1:0] dvd;
    logic [DW-1:0] dvs;
    logic [DW-1:0] rem;
    logic [DW-1:0] quo;
    logic [DW-1:0] acc;
    logic [DW-1:0] fac;
    logic [DW-1:0] expo;
  } cell_t;

  // low half of a 64 x 64 product from three 32 x 32 partial products
  function automatic logic [DW-1:0] mul_lo(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [63:0] ll, lh, hl;
    ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh = {32'd0, a[31:0]} * {32'd0, b[63:32]};
    hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    return ll + {lh[31:0] + hl[31:0], 32'd0};
  endfunction

  function automatic logic [DW-1:0] neg(input logic [DW-1:0] v);
    return ~v + 64'd1;
  endfunction

endpackage
`default_nettype wire

// File: sv/fsa_cell.sv
// One cell of the chain: a restoring divide step and a square-and-multiply
// step on one exponent bit. Depends on fsa_pkg.
`default_nettype none
module fsa_cell
  import fsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  i_valid,
  input  wire cell_t i_data,
  output logic       o_valid,
  output cell_t      o_data
);

  logic  valid_r, valid_nxt;
  cell_t data_r, data_nxt;
  logic [DW:0] shifted, diff;

  always_comb begin
    data_nxt = i_data;
    // shift next dividend bit into the partial remainder
    shifted = {i_data.rem, i_data.dvd[DW-1]};
    diff = shifted - {1'b0, i_data.dvs};
    data_nxt.dvd = {i_data.dvd[DW-2:0], 1'b0};
    if (!diff[DW]) begin
      data_nxt.rem = diff[DW-1:0];
      data_nxt.quo = {i_data.quo[DW-2:0], 1'b1};
    end else begin
      data_nxt.rem = shifted[DW-1:0];
      data_nxt.quo = {i_data.quo[DW-2:0], 1'b0};
    end
    if (i_data.expo[0]) begin
      data_nxt.acc = mul_lo(i_data.acc, i_data.fac);
    end
    data_nxt.fac = mul_lo(i_data.fac, i_data.fac);
    data_nxt.expo = {1'b0, i_data.expo[DW-1:1]};
    valid_nxt = i_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign o_valid = valid_r;
  assign o_data  = data_r;

endmodule
`default_nettype wire

// File: sv/fsa_chain.sv
// Row of identical cells, one per operand bit, all advancing together.
// Depends on fsa_pkg and fsa_cell.
`default_nettype none
module fsa_chain
  import fsa_pkg::*;
#(
  parameter int NCELL = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  i_valid,
  input  wire cell_t i_data,
  output logic       o_valid,
  output cell_t      o_data
);

  logic  v [NCELL+1];
  cell_t d [NCELL+1];

  assign v[0] = i_valid;
  assign d[0] = i_data;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    fsa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .i_valid (v[g]),
      .i_data  (d[g]),
      .o_valid (v[g+1]),
      .o_data  (d[g+1])
    );
  end

  assign o_valid = v[NCELL];
  assign o_data  = d[NCELL];

endmodule
`default_nettype wire

// File: sv/four_state_alu_top.sv
// Four-state ALU: Verilog equality, ordering, bitwise and arithmetic on
// value/unknown bit planes. Uses fsa_pkg and fsa_chain.
//
// Usage: a request enters on in_* (command, operand width and the four
// operand planes in in_tdata) and its result leaves on out_* (value and
// unknown planes). One request is taken every cycle while the output side
// keeps up; every request yields exactly one result, in order.
// The chain length sets the latency. The pipeline is one decode stage, one
// chain cell per operand bit (divide and power need one bit a cell) and one
// output register. One request per cycle flows while the output keeps up.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready drops in the same cycle; it rises as soon as the result is
// taken. Synchronous reset empties the pipeline; no result is pending after.
// Multiply is done in the decode stage, power and division in the chain.
`default_nettype none
module four_state_alu_top
  import fsa_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // command[4:0], operand_width[11:5], left_val[75:12], lhs_unknown[139:76],
  // right_val[203:140], rhs_unknown[267:204], zero fill up to 271
  input  wire logic [271:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // result_value[63:0], result_unknown[127:64]
  output logic [127:0]      out_tdata
);

  localparam int PRESHIFT = DW - MAX_WIDTH;

  logic          adv;
  logic          s0_valid_r;
  cell_t         s0_r, s0_nxt;
  logic          ch_valid;
  cell_t         ch_data;
  logic          out_valid_r;
  logic [DW-1:0] out_val_r, out_val_nxt, out_unk_r, out_unk_nxt;

  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv;

  // decode stage
  always_comb begin
    logic [4:0]    cmd;
    logic [6:0]    w;
    logic [DW-1:0] m, top, lv, lu, rv, ru, known, care, a, b, zero, one, am, bm;
    logic          any, diff, lt, gt, sgn, ln, rn;
    cmd = in_tdata[4:0];
    w = in_tdata[11:5];
    care = '0;
    zero = '0;
    one = '0;
    if (w == 7'd0) w = 7'd1;
    if (w > 7'(MAX_WIDTH)) w = 7'(MAX_WIDTH);
    m = (w >= 7'd64) ? '1 : ((64'd1 << w[5:0]) - 64'd1);
    top = 64'd1 << (w[5:0] - 6'd1);
    lv = in_tdata[75:12] & m;
    lu = in_tdata[139:76] & m;
    rv = in_tdata[203:140] & m;
    ru = in_tdata[267:204] & m;
    any = (lu | ru) != '0;
    known = m & ~lu & ~ru;
    ln = (lv & top) != '0;
    rn = (rv & top) != '0;
    sgn = cmd >= CMD_ADDS;
    am = (sgn && ln) ? (neg(lv) & m) : lv;
    bm = (sgn && rn) ? (neg(rv) & m) : rv;
    a = (cmd >= CMD_LTS) ? (lv ^ top) : lv;
    b = (cmd >= CMD_LTS) ? (rv ^ top) : rv;
    lt = a < b;
    gt = a > b;
    diff = ((lv ^ rv) & known) != '0;

    s0_nxt = '0;
    s0_nxt.cmd = cmd;
    s0_nxt.mask = m;
    s0_nxt.fin = 1'b1;
    s0_nxt.ln = ln;
    s0_nxt.rn = rn;
    s0_nxt.rv = rv;
    s0_nxt.dvd = am << PRESHIFT;
    s0_nxt.dvs = bm;
    s0_nxt.acc = 64'd1;
    s0_nxt.fac = lv;
    s0_nxt.expo = rv;

    case (cmd)
      CMD_EQ, CMD_NE: begin
        if (diff) s0_nxt.fval = {63'd0, cmd == CMD_NE};
        else if (any) begin
          s0_nxt.fval = 64'd1;
          s0_nxt.funk = 64'd1;
        end else s0_nxt.fval = {63'd0, cmd == CMD_EQ};
      end
      CMD_CASE: s0_nxt.fval = {63'd0, (((lv ^ rv) | (lu ^ ru)) & m) == '0};
      CMD_CASEZ: begin
        care = m & ~((lu & ~lv) | (ru & ~rv));
        s0_nxt.fval = {63'd0, (((lv ^ rv) | (lu ^ ru)) & care) == '0};
      end
      CMD_CASEX: begin
        care = m & ~(lu | ru);
        s0_nxt.fval = {63'd0, ((lv ^ rv) & care) == '0};
      end
      CMD_WILD: begin
        care = m & ~ru;
        if (((lv ^ rv) & care & ~lu) != '0) s0_nxt.fval = '0;
        else if ((lu & care) != '0) begin
          s0_nxt.fval = 64'd1;
          s0_nxt.funk = 64'd1;
        end else s0_nxt.fval = 64'd1;
      end
      CMD_LTU, CMD_LEU, CMD_GTU, CMD_GEU, CMD_LTS, CMD_LES, CMD_GTS, CMD_GES: begin
        if (any) begin
          s0_nxt.fval = 64'd1;
          s0_nxt.funk = 64'd1;
        end else if (cmd == CMD_LTU || cmd == CMD_LTS) s0_nxt.fval = {63'd0, lt};
        else if (cmd == CMD_LEU || cmd == CMD_LES) s0_nxt.fval = {63'd0, !gt};
        else if (cmd == CMD_GTU || cmd == CMD_GTS) s0_nxt.fval = {63'd0, gt};
        else s0_nxt.fval = {63'd0, !lt};
      end
      CMD_AND: begin
        zero = ((~lu & ~lv) | (~ru & ~rv)) & m;
        one = (~lu & lv) & (~ru & rv) & m;
        s0_nxt.funk = m & ~(zero | one);
        s0_nxt.fval = (one | s0_nxt.funk) & m;
      end
      CMD_OR: begin
        one = ((~lu & lv) | (~ru & rv)) & m;
        zero = (~lu & ~lv) & (~ru & ~rv) & m;
        s0_nxt.funk = m & ~(zero | one);
        s0_nxt.fval = (one | s0_nxt.funk) & m;
      end
      CMD_XOR: begin
        s0_nxt.funk = (lu | ru) & m;
        s0_nxt.fval = ((lv ^ rv) | s0_nxt.funk) & m;
      end
      CMD_ADDU, CMD_ADDS, CMD_SUBU, CMD_SUBS, CMD_MULU, CMD_MULS, CMD_POWU, CMD_POWS,
      CMD_DIVU, CMD_MODU, CMD_DIVS, CMD_REMS, CMD_MODS: begin
        if (any) begin
          s0_nxt.fval = m;
          s0_nxt.funk = m;
        end else if (cmd == CMD_ADDU || cmd == CMD_ADDS) s0_nxt.fval = (lv + rv) & m;
        else if (cmd == CMD_SUBU || cmd == CMD_SUBS) s0_nxt.fval = (lv - rv) & m;
        else if (cmd == CMD_MULU || cmd == CMD_MULS) s0_nxt.fval = mul_lo(lv, rv) & m;
        else if (cmd == CMD_POWS && rn) begin
          // negative exponent: only bases 0, 1 and all ones stay non-zero
          if (lv == '0) begin
            s0_nxt.fval = m;
            s0_nxt.funk = m;
          end else if (lv == 64'd1) s0_nxt.fval = 64'd1;
          else if (lv == m) s0_nxt.fval = rv[0] ? m : 64'd1;
          else s0_nxt.fval = '0;
        end else if (cmd == CMD_POWU || cmd == CMD_POWS) s0_nxt.fin = 1'b0;
        else if (rv == '0) begin
          s0_nxt.fval = m;
          s0_nxt.funk = m;
        end else s0_nxt.fin = 1'b0;
      end
      default: begin
        s0_nxt.fval = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  fsa_chain #(.NCELL(MAX_WIDTH)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .i_valid (s0_valid_r),
    .i_data  (s0_r),
    .o_valid (ch_valid),
    .o_data  (ch_data)
  );

  // sign fix-up and selection after the chain
  always_comb begin
    logic [DW-1:0] q, r;
    q = (ch_data.ln != ch_data.rn) ? neg(ch_data.quo) : ch_data.quo;
    r = ch_data.ln ? neg(ch_data.rem) : ch_data.rem;
    r = r & ch_data.mask;
    out_unk_nxt = '0;
    if (ch_data.fin) begin
      out_val_nxt = ch_data.fval;
      out_unk_nxt = ch_data.funk;
    end else begin
      case (ch_data.cmd)
        CMD_POWU, CMD_POWS: out_val_nxt = ch_data.acc;
        CMD_DIVU: out_val_nxt = ch_data.quo;
        CMD_MODU: out_val_nxt = ch_data.rem;
        CMD_DIVS: out_val_nxt = q;
        CMD_REMS: out_val_nxt = r;
        CMD_MODS: out_val_nxt = (r != '0 && ch_data.ln != ch_data.rn) ? (r + ch_data.rv) : r;
        default:  out_val_nxt = '0;
      endcase
      out_val_nxt = out_val_nxt & ch_data.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_val_r <= out_val_nxt;
      out_unk_r <= out_unk_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_unk_r, out_val_r};

endmodule
`default_nettype wire

// File: sv/fsa_checker.sv
// Port-level checks on the four-state ALU top level, bound to it below.
// Depends on four_state_alu_top's ports only.
`default_nettype none
module fsa_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // input side is ready exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stall");

  // nothing pending straight after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // unknown bits of a result always read as x, never z
  a_x_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[127:64] & ~out_tdata[63:0]) == 64'd0))
    else $error("z in result");

endmodule

bind four_state_alu_top fsa_checker u_fsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// File: dv/tb_four_state_alu_top.sv
// Testbench for four_state_alu_top: directed and random requests on the input
// stream, results checked in order against a behavioural model of the ALU.
// Depends on fsa_pkg and four_state_alu_top.
`timescale 1ns / 100ps
module tb_four_state_alu_top
  import fsa_pkg::*;
();

  localparam logic [4:0] CMD_SPARE_A = 5'd30;
  localparam logic [4:0] CMD_SPARE_B = 5'd31;

  typedef struct {
    logic [63:0] val;
    logic [63:0] unk;
  } planes_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // command, operand_width, left_val, lhs_unknown, right_val, rhs_unknown, zero fill
  logic [271:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // result_value, result_unknown
  logic [127:0] out_tdata;

  planes_t pending_results[$];
  int mismatches = 0;

  four_state_alu_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] wmask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] negate_w(logic [63:0] v, logic [63:0] m);
    return (~v + 64'd1) & m;
  endfunction

  function automatic logic [63:0] raise_w(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) & m;
      b = (b * b) & m;
      e = e >> 1;
    end
    return acc & m;
  endfunction

  function automatic planes_t alu_result(logic [4:0] cmd, logic [6:0] wid,
      logic [63:0] lv, logic [63:0] lu, logic [63:0] rv, logic [63:0] ru);
    planes_t r;
    int w;
    int kind;
    logic [63:0] m, top, known, care, zero, one, a, b, am, bm, q, rm;
    bit any, sgn, ln, rn;
    w = wid;
    if (w < 1) w = 1;
    if (w > 64) w = 64;
    m = wmask(w);
    top = 64'd1 << (w - 1);
    lv &= m; lu &= m; rv &= m; ru &= m;
    any = (lu | ru) != 0;
    known = m & ~lu & ~ru;
    r.val = 0; r.unk = 0;
    case (cmd)
      CMD_EQ, CMD_NE: begin
        if (((lv ^ rv) & known) != 0) r.val = (cmd == CMD_NE);
        else if (any) begin r.val = 1; r.unk = 1; end
        else r.val = (cmd == CMD_EQ);
      end
      CMD_CASE: r.val = (((lv ^ rv) | (lu ^ ru)) & m) == 0;
      CMD_CASEZ: begin
        care = m & ~((lu & ~lv) | (ru & ~rv));
        r.val = (((lv ^ rv) | (lu ^ ru)) & care) == 0;
      end
      CMD_CASEX: r.val = ((lv ^ rv) & m & ~(lu | ru)) == 0;
      CMD_WILD: begin
        care = m & ~ru;
        if (((lv ^ rv) & care & ~lu) != 0) r.val = 0;
        else if ((lu & care) != 0) begin r.val = 1; r.unk = 1; end
        else r.val = 1;
      end
      CMD_LTU, CMD_LEU, CMD_GTU, CMD_GEU, CMD_LTS, CMD_LES, CMD_GTS, CMD_GES: begin
        if (any) begin r.val = 1; r.unk = 1; end
        else begin
          a = lv; b = rv;
          if (cmd >= CMD_LTS) begin a ^= top; b ^= top; end
          case ((cmd - CMD_LTU) % 4)
            0: r.val = a < b;
            1: r.val = !(a > b);
            2: r.val = a > b;
            default: r.val = !(a < b);
          endcase
        end
      end
      CMD_AND: begin
        zero = ((~lu & ~lv) | (~ru & ~rv)) & m;
        one = (~lu & lv) & (~ru & rv) & m;
        r.unk = m & ~(zero | one);
        r.val = one | r.unk;
      end
      CMD_OR: begin
        one = ((~lu & lv) | (~ru & rv)) & m;
        zero = (~lu & ~lv) & (~ru & ~rv) & m;
        r.unk = m & ~(zero | one);
        r.val = one | r.unk;
      end
      CMD_XOR: begin
        r.unk = (lu | ru) & m;
        r.val = ((lv ^ rv) | r.unk) & m;
      end
      default: if (cmd >= CMD_ADDU && cmd <= CMD_MODS) begin
        sgn = cmd >= CMD_ADDS;
        kind = sgn ? cmd - CMD_ADDS : cmd - CMD_ADDU;
        if (any) begin r.val = m; r.unk = m; end
        else if (kind == 0) r.val = (lv + rv) & m;
        else if (kind == 1) r.val = (lv - rv) & m;
        else if (kind == 2) r.val = (lv * rv) & m;
        else if (kind == 3) begin
          if (sgn && (rv & top) != 0) begin
            if (lv == 0) begin r.val = m; r.unk = m; end
            else if (lv == 1) r.val = 1;
            else if (lv == m) r.val = rv[0] ? m : 64'd1;
            else r.val = 0;
          end else r.val = raise_w(lv, rv, m);
        end
        else if (rv == 0) begin r.val = m; r.unk = m; end
        else if (!sgn) r.val = (kind == 4) ? lv / rv : lv % rv;
        else begin
          ln = (lv & top) != 0; rn = (rv & top) != 0;
          am = ln ? negate_w(lv, m) : lv;
          bm = rn ? negate_w(rv, m) : rv;
          q = am / bm; rm = am % bm;
          if (ln != rn) q = negate_w(q, m);
          if (ln) rm = negate_w(rm, m);
          if (kind == 4) r.val = q & m;
          else if (kind == 6 && rm != 0 && ln != rn) r.val = (rm + rv) & m;
          else r.val = rm & m;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // drive one request and hold it until accepted
  task automatic send_request(logic [4:0] cmd, logic [6:0] wid, logic [63:0] lv,
      logic [63:0] lu, logic [63:0] rv, logic [63:0] ru, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tdata <= {4'd0, ru, rv, lu, lv, wid, cmd};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(alu_result(cmd, wid, lv, lu, rv, ru));
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [4:0] c;
    send_request(CMD_EQ, 7'd0, 64'd1, 0, 64'd1, 0);
    send_request(CMD_EQ, 7'd127, '1, 0, '1, 0);
    send_request(CMD_SPARE_A, 7'd8, '1, '1, '1, '1);
    send_request(CMD_SPARE_B, 7'd8, 64'd5, 0, 64'd5, 0);
    send_request(CMD_EQ, 7'd4, 64'b1010, 64'b0001, 64'b1011, 0);
    send_request(CMD_NE, 7'd4, 64'b1010, 64'b0001, 64'b0011, 0);
    send_request(CMD_WILD, 7'd4, 64'b1010, 0, 64'b1000, 64'b0011);
    send_request(CMD_DIVS, 7'd8, 64'h80, 0, 64'hff, 0);
    send_request(CMD_DIVU, 7'd8, 64'h12, 0, 0, 0);
    send_request(CMD_MODS, 7'd8, 64'hf9, 0, 64'h03, 0);
    send_request(CMD_REMS, 7'd8, 64'hf9, 0, 64'h03, 0);
    send_request(CMD_POWS, 7'd8, 0, 0, 64'hfe, 0);
    send_request(CMD_POWS, 7'd8, 1, 0, 64'hfe, 0);
    send_request(CMD_POWS, 7'd8, 64'hff, 0, 64'hfd, 0);
    send_request(CMD_POWS, 7'd8, 64'hff, 0, 64'hfe, 0);
    send_request(CMD_POWS, 7'd8, 64'h03, 0, 64'hff, 0);
    send_request(CMD_POWU, 7'd64, 64'd7, 0, 0, 0);
    send_request(CMD_ADDU, 7'd64, '1, 0, 64'd1, 64'h10);
    send_request(CMD_GTS, 7'd64, 64'h8000_0000_0000_0000, 0, 64'd1, 0);
    for (int i = 0; i <= 29; i++) begin
      c = 5'(i);
      send_request(c, 7'd64, rand64(), 0, rand64(), 0);
    end
  endtask

  task automatic test_random(int count);
    logic [4:0] cmd;
    logic [6:0] wid;
    logic [63:0] lu, ru, rv;
    int p;
    for (int i = 0; i < count; i++) begin
      cmd = 5'($urandom_range(31));
      p = $urandom_range(99);
      wid = (p < 5) ? 7'($urandom_range(127)) : (p < 60) ? 7'($urandom_range(16, 1))
          : 7'($urandom_range(64, 1));
      p = $urandom_range(99);
      lu = (p < 60) ? 64'd0 : (p < 85) ? (rand64() & rand64() & rand64()) : rand64();
      p = $urandom_range(99);
      ru = (p < 60) ? 64'd0 : (p < 85) ? (rand64() & rand64() & rand64()) : rand64();
      rv = rand64();
      if ($urandom_range(9) == 0) rv = $urandom_range(3);
      else if ($urandom_range(9) == 0) rv = '1;
      send_request(cmd, wid, rand64(), lu, rv, ru, $urandom_range(3) == 0);
    end
  endtask

  // output stall pattern
  initial begin
    int g;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(negedge clk);
      end
      out_tready <= 1;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    planes_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[63:0] !== exp_r.val || out_tdata[127:64] !== exp_r.unk) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value exp %h got %h, unknown exp %h got %h",
                     exp_r.val, out_tdata[63:0], exp_r.unk, out_tdata[127:64]);
        end
      end
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random(1500);
    in_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: files.f
sv/fsa_pkg.sv
sv/fsa_cell.sv
sv/fsa_chain.sv
sv/four_state_alu_top.sv
sv/fsa_checker.sv
dv/tb_four_state_alu_top.sv
